[rtl/led_blink_code_generator_macros.svh]
// Assertion macros shared by the blink-code generator RTL.
`ifndef LED_BLINK_CODE_GENERATOR_MACROS_SVH
`define LED_BLINK_CODE_GENERATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[rtl/lbc_pkg.sv]
// Package: beat types, command codes and constants of the blink-code generator.
`timescale 1ns / 1ps
package lbc_pkg;

  // Command codes carried by an input beat
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_BLINK = 2'd1,
    CMD_SET   = 2'd2,
    CMD_FAULT = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_LONG_DELAY  = 2'd0,
    REG_SHORT_DELAY = 2'd1,
    REG_FAULT_DELAY = 2'd2
  } reg_idx_e;

  localparam int unsigned DelayW = 24;
  localparam int unsigned NumW   = 31;
  localparam int unsigned TogW   = 6;

  localparam logic [DelayW-1:0] LongDelayRst  = 24'd1000000;
  localparam logic [DelayW-1:0] ShortDelayRst = 24'd200000;
  localparam logic [DelayW-1:0] FaultDelayRst = 24'd210000;

  // Fault pattern length: 2*FAULT_BLINKS toggles, kept in a 6-bit counter
  localparam int unsigned FAULT_BLINKS = 20;
  localparam logic [TogW-1:0] FaultToggles = TogW'((2 * FAULT_BLINKS) % 64);

  // Reciprocal of ten for a 32-bit dividend: q = (x * Recip10) >> 35
  localparam logic [31:0] Recip10 = 32'hCCCC_CCCD;

  typedef struct packed {
    logic [1:0]      command;
    logic [NumW-1:0] number;
    logic            level;
  } in_beat_t;

  typedef struct packed {
    logic led_pin;
    logic busy_res;
    logic halted;
  } out_beat_t;

endpackage

[rtl/led_blink_code_generator.sv]
// Blink-code generator: a status LED sequencer driven by commands and ticks.
//
// Usage:
//  - Input channel (in_valid_i / in_stall_o / in_data_i): one beat is a tick or a
//    command (blink number, set led, fault). Non-tick commands are dropped while a
//    sequence runs or after the fault pattern has halted the block.
//  - Output channel (out_valid_o / out_stall_i / out_data_o): exactly one beat per
//    input beat, carrying pin level (active low), busy and halted after the update.
//  - Config port (cfg_we_i / cfg_idx_i / cfg_wdata_i): the three delay registers,
//    written while idle; index 3 is ignored. A zero delay acts as one tick.
//  - Each result is registered, in the result register or, while that one is held,
//    in the skid entry. Throughput: one beat per cycle unless stalled. The digit
//    split is one 31x32 reciprocal multiply registered with the remaining value.
//  - Stall: a two-entry output (result register plus skid) keeps accepting while
//    one result waits; in_stall_o rises only when both entries are full.
//  - Reset: LED lit, idle, not halted, delays at their default values.
`timescale 1ns / 1ps
`include "led_blink_code_generator_macros.svh"

module led_blink_code_generator
  import lbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  in_beat_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output out_beat_t         out_data_o,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [DelayW-1:0] cfg_wdata_i
);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_LEAD   = 3'd1;
  localparam logic [2:0] PH_TOGGLE = 3'd2;
  localparam logic [2:0] PH_GAP    = 3'd3;
  localparam logic [2:0] PH_TAIL   = 3'd4;
  localparam logic [2:0] PH_FAULT  = 3'd5;
  localparam logic [2:0] PH_HALT   = 3'd6;

  // Delay registers
  logic [DelayW-1:0] long_q, short_q, fault_q;

  // Sequencer state
  logic              led_q, led_d;
  logic              saved_q, saved_d;
  logic [NumW-1:0]   rem_q, rem_d;
  logic [NumW-1:0]   quo_q, quo_d;
  logic [2:0]        phase_q, phase_d;
  logic [TogW-1:0]   tog_q, tog_d;
  logic [DelayW-1:0] wait_q, wait_d;
  logic              halt_q, halt_d;

  // Output register and skid entry
  logic      out_v_q, skid_v_q;
  out_beat_t out_q, skid_q, res;

  logic accept, pop;
  logic busy, stopped;
  logic [DelayW-1:0] long_eff, short_eff, fault_eff;
  logic [3:0] quo_x10, digit;
  logic [62:0] prod;

  assign accept = in_valid_i && !skid_v_q;
  assign pop    = out_v_q && !out_stall_i;

  assign busy    = (phase_q != PH_IDLE) && (phase_q != PH_HALT);
  assign stopped = halt_q || (phase_q == PH_HALT);

  // A zero delay counts as one tick
  assign long_eff  = (long_q  == '0) ? DelayW'(1) : long_q;
  assign short_eff = (short_q == '0) ? DelayW'(1) : short_q;
  assign fault_eff = (fault_q == '0) ? DelayW'(1) : fault_q;

  // Lowest decimal digit: rem - 10*quo, only the low nibble matters
  assign quo_x10 = 4'(quo_q[3:0] * 4'd10);
  assign digit   = 4'(rem_q[3:0] - quo_x10);

  // Quotient by ten of the next remaining value, registered with it
  assign prod  = 63'(rem_d) * 63'(Recip10);
  assign quo_d = NumW'(prod >> 35);

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_q  <= LongDelayRst;
      short_q <= ShortDelayRst;
      fault_q <= FaultDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_LONG_DELAY:  long_q  <= cfg_wdata_i;
        REG_SHORT_DELAY: short_q <= cfg_wdata_i;
        REG_FAULT_DELAY: fault_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer next state for the accepted beat
  always_comb begin
    led_d   = led_q;
    saved_d = saved_q;
    rem_d   = rem_q;
    phase_d = phase_q;
    tog_d   = tog_q;
    wait_d  = wait_q;
    halt_d  = halt_q;
    if (accept) begin
      if (in_data_i.command == CMD_TICK) begin
        if (busy) begin
          wait_d = (wait_q != '0) ? wait_q - DelayW'(1) : wait_q;
          if (wait_q <= DelayW'(1)) begin
            case (phase_q)
              PH_LEAD, PH_GAP: begin
                if (rem_q != '0) begin
                  // start a digit group: 2*(d+1) toggles, first one now
                  tog_d   = TogW'({digit, 1'b1});
                  phase_d = PH_TOGGLE;
                  led_d   = ~led_q;
                  wait_d  = short_eff;
                end else begin
                  led_d   = 1'b1;
                  phase_d = PH_TAIL;
                  wait_d  = long_eff;
                end
              end
              PH_TOGGLE: begin
                if (tog_q != '0) begin
                  led_d  = ~led_q;
                  tog_d  = tog_q - TogW'(1);
                  wait_d = short_eff;
                end else begin
                  rem_d   = quo_q;
                  phase_d = PH_GAP;
                  wait_d  = long_eff;
                end
              end
              PH_TAIL: begin
                led_d   = saved_q;
                phase_d = PH_IDLE;
              end
              PH_FAULT: begin
                if (tog_q != '0) begin
                  led_d  = ~led_q;
                  tog_d  = tog_q - TogW'(1);
                  wait_d = fault_eff;
                end else begin
                  halt_d  = 1'b1;
                  phase_d = PH_HALT;
                end
              end
              default: ;
            endcase
          end
        end
      end else if (!busy && !stopped) begin
        case (in_data_i.command)
          CMD_BLINK: begin
            saved_d = led_q;
            led_d   = 1'b0;
            rem_d   = in_data_i.number;
            phase_d = PH_LEAD;
            wait_d  = long_eff;
          end
          CMD_SET: begin
            led_d = in_data_i.level;
          end
          CMD_FAULT: begin
            led_d   = ~led_q;
            tog_d   = (FaultToggles != '0) ? FaultToggles - TogW'(1) : FaultToggles;
            phase_d = PH_FAULT;
            wait_d  = fault_eff;
          end
          default: ;
        endcase
      end
    end
  end

  // Result of the beat, taken after the update
  always_comb begin
    res.led_pin  = ~led_d;
    res.busy_res = (phase_d != PH_IDLE) && (phase_d != PH_HALT);
    res.halted   = halt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      led_q   <= 1'b1;
      saved_q <= 1'b0;
      rem_q   <= '0;
      quo_q   <= '0;
      phase_q <= PH_IDLE;
      tog_q   <= '0;
      wait_q  <= '0;
      halt_q  <= 1'b0;
    end else begin
      led_q   <= led_d;
      saved_q <= saved_d;
      rem_q   <= rem_d;
      quo_q   <= quo_d;
      phase_q <= phase_d;
      tog_q   <= tog_d;
      wait_q  <= wait_d;
      halt_q  <= halt_d;
    end
  end

  // Output register with skid entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= accept;
      end
    end else if (accept) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_v_q || pop) begin
      if (skid_v_q) begin
        out_q <= skid_q;
      end else if (accept) begin
        out_q <= res;
      end
    end else if (accept) begin
      skid_q <= res;
    end
  end

  assign in_stall_o  = skid_v_q;
  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // Checks
  `LBC_ASSERT_IMPLIES(a_skid_behind_main, clk_i, rst_ni, skid_v_q, out_v_q)
  `LBC_ASSERT_IMPLIES(a_halt_phase, clk_i, rst_ni, halt_q, phase_q == PH_HALT)
  `LBC_ASSERT_IMPLIES(a_busy_waits, clk_i, rst_ni, busy, wait_q != '0)
  `LBC_ASSERT_NEXT(a_halt_sticks, clk_i, rst_ni, halt_q, halt_q)

endmodule

[bench/lbc_status_checker.sv]
// Checker: predicts the LED status beats of the blink-code generator and compares them.
`timescale 1ns / 1ps
module lbc_status_checker
  import lbc_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  in_beat_t          in_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  out_beat_t         out_data_i,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [DelayW-1:0] cfg_wdata_i,
  output int unsigned       errors_o,
  output int unsigned       pending_o,
  output int unsigned       checked_o
);

  // Sequencer phases as the predictor tracks them
  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_LEAD,
    SEQ_TOGGLE,
    SEQ_GAP,
    SEQ_TAIL,
    SEQ_FAULT,
    SEQ_HALT
  } seq_e;

  localparam int unsigned MaxPrinted = 100;

  // Delay registers as last written
  logic [DelayW-1:0] long_dly, short_dly, fault_dly;

  // Predicted sequencer state
  logic              lit, saved_lit, halt_seen;
  logic [NumW-1:0]   digits_left;
  seq_e              seq;
  logic [TogW-1:0]   flips_left;
  logic [DelayW-1:0] ticks_left;

  out_beat_t   status_due[$];
  out_beat_t   next_status, want;
  int unsigned n_err, n_due, n_checked;

  assign errors_o  = n_err;
  assign pending_o = n_due;
  assign checked_o = n_checked;

  function automatic logic [DelayW-1:0] min_one(input logic [DelayW-1:0] v);
    return (v == '0) ? DelayW'(1) : v;
  endfunction

  task automatic note_mismatch(input string msg);
    if (n_err < MaxPrinted) $display("[%0t] MISMATCH: %s", $realtime, msg);
    n_err++;
  endtask

  task automatic flip(input logic [DelayW-1:0] dly);
    lit = ~lit;
    if (flips_left != '0) flips_left--;
    ticks_left = min_one(dly);
  endtask

  // Open the next digit group, or the closing lit pause when no digits remain
  task automatic next_group();
    logic [3:0] dig;
    if (digits_left != '0) begin
      dig = 4'(digits_left % 10);
      flips_left = TogW'(2 * (dig + 1));
      seq = SEQ_TOGGLE;
      flip(short_dly);
    end else begin
      lit = 1'b1;
      seq = SEQ_TAIL;
      ticks_left = min_one(long_dly);
    end
  endtask

  // Action taken on the tick that runs a wait down to zero
  task automatic wait_done();
    case (seq)
      SEQ_LEAD, SEQ_GAP: next_group();
      SEQ_TOGGLE: begin
        if (flips_left != '0) begin
          flip(short_dly);
        end else begin
          digits_left = digits_left / 10;
          seq = SEQ_GAP;
          ticks_left = min_one(long_dly);
        end
      end
      SEQ_TAIL: begin
        lit = saved_lit;
        seq = SEQ_IDLE;
      end
      SEQ_FAULT: begin
        if (flips_left != '0) begin
          flip(fault_dly);
        end else begin
          halt_seen = 1'b1;
          seq = SEQ_HALT;
        end
      end
      default: ;
    endcase
  endtask

  // One input beat in, the status after the update out
  task automatic step_led(input in_beat_t b, output out_beat_t r);
    logic active, stopped;
    active  = (seq != SEQ_IDLE) && (seq != SEQ_HALT);
    stopped = halt_seen || (seq == SEQ_HALT);
    if (cmd_e'(b.command) == CMD_TICK) begin
      if (active) begin
        if (ticks_left != '0) ticks_left--;
        if (ticks_left == '0) wait_done();
      end
    end else if (!active && !stopped) begin
      case (cmd_e'(b.command))
        CMD_BLINK: begin
          saved_lit = lit;
          lit = 1'b0;
          digits_left = b.number;
          seq = SEQ_LEAD;
          ticks_left = min_one(long_dly);
        end
        CMD_SET: lit = b.level;
        default: begin
          flips_left = TogW'(2 * FAULT_BLINKS);
          seq = SEQ_FAULT;
          flip(fault_dly);
        end
      endcase
    end
    r.led_pin  = ~lit;
    r.busy_res = (seq != SEQ_IDLE) && (seq != SEQ_HALT);
    r.halted   = halt_seen;
  endtask

  // Register writes, prediction per accepted input beat, comparison per result beat
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_dly    = LongDelayRst;
      short_dly   = ShortDelayRst;
      fault_dly   = FaultDelayRst;
      lit         = 1'b1;
      saved_lit   = 1'b0;
      digits_left = '0;
      seq         = SEQ_IDLE;
      flips_left  = '0;
      ticks_left  = '0;
      halt_seen   = 1'b0;
      status_due.delete();
      n_due       = 0;
      n_err       = 0;
      n_checked   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_LONG_DELAY:  long_dly  = cfg_wdata_i;
          REG_SHORT_DELAY: short_dly = cfg_wdata_i;
          REG_FAULT_DELAY: fault_dly = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        step_led(in_data_i, next_status);
        status_due.push_back(next_status);
      end
      if (out_valid_i && !out_stall_i) begin
        if (status_due.size() == 0) begin
          note_mismatch($sformatf("status beat %b with none expected", out_data_i));
        end else begin
          want = status_due.pop_front();
          if (out_data_i.led_pin !== want.led_pin)
            note_mismatch($sformatf("led_pin got %b want %b at beat %0d",
                                    out_data_i.led_pin, want.led_pin, n_checked));
          if (out_data_i.busy_res !== want.busy_res)
            note_mismatch($sformatf("busy_res got %b want %b at beat %0d",
                                    out_data_i.busy_res, want.busy_res, n_checked));
          if (out_data_i.halted !== want.halted)
            note_mismatch($sformatf("halted got %b want %b at beat %0d",
                                    out_data_i.halted, want.halted, n_checked));
          n_checked++;
        end
      end
      n_due = status_due.size();
    end
  end

endmodule

[bench/tb_led_blink_code_generator.sv]
// Testbench top: drives commands, ticks and delay settings into the blink-code generator.
`timescale 1ns / 1ps
module tb_led_blink_code_generator;
  import lbc_pkg::*;

  localparam logic [1:0]      RegUnused     = 2'd3;  // index with no register behind it
  localparam int unsigned     QuietLimit    = 2000;
  localparam int unsigned     NumPhases     = 8;
  localparam int unsigned     ItemsPerPhase = 25;
  localparam int unsigned     SettleCycles  = 4;
  localparam logic [NumW-1:0] NumMax        = '1;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  in_beat_t          in_data   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  out_beat_t         out_data;
  logic              cfg_we    = 1'b0;
  logic [1:0]        cfg_idx   = '0;
  logic [DelayW-1:0] cfg_wdata = '0;

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  // delays as the block applies them (zero counts as one tick)
  int unsigned long_eff, short_eff, fault_eff;
  int unsigned beats_sent    = 0;
  int unsigned settings_used = 0;
  int unsigned quiet_cycles  = 0;
  int unsigned n_errors, n_pending, n_checked;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  led_blink_code_generator u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  lbc_status_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_i  (in_stall),
    .in_data_i   (in_data),
    .out_valid_i (out_valid),
    .out_stall_i (out_stall),
    .out_data_i  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .errors_o    (n_errors),
    .pending_o   (n_pending),
    .checked_o   (n_checked)
  );

  // Receiver backpressure
  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  // Watchdog: too long without any beat moving on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QuietLimit) begin
      $display("Timeout: no beat moved for %0d cycles", QuietLimit);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // One input beat, with random sender gaps ahead of it
  task automatic send(input cmd_e cmd, input logic [NumW-1:0] num, input logic lvl);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= '{command: cmd, number: num, level: lvl};
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic tick();
    send(CMD_TICK, NumW'($urandom), 1'($urandom));
  endtask

  // Non-tick command with random fields; only sent when the block must drop it
  task automatic stray_cmd();
    send(cmd_e'($urandom_range(3, 1)), NumW'($urandom), 1'($urandom));
  endtask

  // Hold off until every status beat is back and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk_i); while (n_pending != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_mode(input int unsigned mode);
    case (mode)
      0: begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
      1: begin tx_idle_pct = 52; rx_stall_pct <= 0;  end
      2: begin tx_idle_pct = 0;  rx_stall_pct <= 52; end
      default: begin tx_idle_pct = 27; rx_stall_pct <= 27; end
    endcase
  endtask

  // Write all three delays plus a junk write to the unused index
  task automatic set_delays(input logic [DelayW-1:0] l, s, f);
    cfg_we    <= 1'b1;
    cfg_idx   <= REG_LONG_DELAY;
    cfg_wdata <= l;
    @(posedge clk_i);
    cfg_idx   <= REG_SHORT_DELAY;
    cfg_wdata <= s;
    @(posedge clk_i);
    cfg_idx   <= REG_FAULT_DELAY;
    cfg_wdata <= f;
    @(posedge clk_i);
    cfg_idx   <= RegUnused;
    cfg_wdata <= DelayW'($urandom);
    @(posedge clk_i);
    cfg_we    <= 1'b0;
    long_eff  = (l == '0) ? 1 : l;
    short_eff = (s == '0) ? 1 : s;
    fault_eff = (f == '0) ? 1 : f;
    settings_used++;
  endtask

  // Ticks from a blink command until the block is idle again
  function automatic int unsigned seq_ticks(input logic [NumW-1:0] num);
    int unsigned t;
    logic [NumW-1:0] v;
    t = 2 * long_eff;
    v = num;
    while (v != '0) begin
      t += long_eff + 2 * short_eff * (v % 10 + 1);
      v = v / 10;
    end
    return t;
  endfunction

  function automatic logic [NumW-1:0] pick_num();
    int unsigned sel;
    sel = $urandom_range(7);
    if (sel == 0) return ($urandom_range(1) != 0) ? NumMax : '0;
    if (sel < 3) return NumW'($urandom);
    return NumW'($urandom_range(999));
  endfunction

  // Full blink sequence, with dropped commands sprinkled in while it runs
  task automatic run_blink(input logic [NumW-1:0] num);
    int unsigned left;
    left = seq_ticks(num);
    send(CMD_BLINK, num, 1'($urandom));
    while (left != 0) begin
      if ($urandom_range(99) < 8) stray_cmd();
      tick();
      left--;
    end
  endtask

  initial begin
    int unsigned counted, pick;
    logic [NumW-1:0] num;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset delays are far too long to run out; stay with idle commands
    tick();
    send(CMD_SET, NumMax, 1'b0);
    send(CMD_SET, '0, 1'b1);
    send(CMD_TICK, NumMax, 1'b1);

    // Full-scale delays, again idle commands only
    drain();
    set_delays('1, '1, '1);
    send(CMD_SET, NumMax, 1'b0);
    tick();
    send(CMD_SET, '0, 1'b1);

    // Zero delays behave as one tick
    drain();
    set_delays('0, '0, '0);
    run_blink('0);
    send(CMD_SET, '0, 1'b0);
    send(CMD_BLINK, NumW'(1), 1'b0);
    // commands while a sequence runs are dropped
    send(CMD_FAULT, NumMax, 1'b1);
    send(CMD_SET, '0, 1'b1);
    send(CMD_BLINK, NumMax, 1'b1);
    repeat (seq_ticks(NumW'(1))) tick();

    // Random sequences under each idling mode and a fresh set of short delays
    for (int unsigned ph = 0; ph < NumPhases; ph++) begin
      drain();
      set_mode(ph % 4);
      set_delays(DelayW'($urandom_range(3)), DelayW'($urandom_range(3)),
                 DelayW'($urandom_range(3)));
      counted = 0;
      while (counted < ItemsPerPhase) begin
        pick = $urandom_range(9);
        if (pick < 6) begin
          num = pick_num();
          counted += seq_ticks(num) + 1;
          run_blink(num);
        end else if (pick < 8) begin
          send(CMD_SET, NumW'($urandom), 1'($urandom));
          counted++;
        end else begin
          repeat ($urandom_range(3, 1)) tick();
        end
      end
    end

    // Fault pattern last: the block halts for the rest of the run
    drain();
    set_delays(DelayW'($urandom_range(3)), DelayW'($urandom_range(3)),
               DelayW'($urandom_range(3)));
    send(CMD_FAULT, NumW'($urandom), 1'($urandom));
    repeat (2 * FAULT_BLINKS * fault_eff) begin
      if ($urandom_range(99) < 8) stray_cmd();
      tick();
    end
    repeat (12) begin
      if ($urandom_range(1) != 0) tick();
      else stray_cmd();
    end

    drain();
    @(negedge clk_i);
    $display("Sent %0d beats over %0d delay settings: zero and full-scale delays,",
             beats_sent, settings_used);
    $display("blinks, level sets, dropped commands and the fault halt; %0d status beats checked.",
             n_checked);
    if (n_errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
